### rtl/cvh_pkg.sv
// Shared constants and types for the clamped velocity histogram.
package cvh_pkg;

   localparam int MAX_TYPES   = 4;
   localparam int BINS        = 256;
   localparam int COUNT_WIDTH = 32;
   localparam int AXES        = 3;

   localparam int ROWS   = MAX_TYPES * AXES;
   localparam int DEPTH  = ROWS * BINS;
   localparam int BIN_W  = $clog2(BINS);
   localparam int ADDR_W = $clog2(DEPTH);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Reset values of the configuration registers
   localparam logic [30:0] HALF_RANGE_RESET  = 31'd65536;
   localparam logic [30:0] BIN_SCALE_RESET   = 31'd8388608;
   localparam logic [8:0]  BINS_IN_USE_RESET = 9'd256;

   typedef enum logic [1:0] {
      OP_ACCUMULATE = 2'd0,
      OP_READ       = 2'd1,
      OP_CLEAR      = 2'd2,
      OP_UNUSED     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_HALF_RANGE  = 2'd0,
      CSR_BIN_SCALE   = 2'd1,
      CSR_BINS_IN_USE = 2'd2,
      CSR_NONE        = 2'd3
   } csr_index_type;

   // Pipeline enables for the bin locator
   typedef struct packed {
      logic load_sum;
      logic load_prod;
   } calc_ctl_type;

   // Located bin and its clamp flag
   typedef struct packed {
      logic [BIN_W-1:0] bin;
      logic             clamped;
   } loc_type;

endpackage

### rtl/clamped_velocity_histogram.sv
// Top level of the clamped velocity histogram: control, registers and result stage.
//
// Requests arrive on the req_ channel (valid/stall) and each gives exactly one
// response on the rsp_ channel. Operation accumulate bins a Q16.16 sample into
// the row of its atom type and axis and increments that counter, saturating;
// read returns one counter; clear zeroes one counter.
// Each request passes through offset sum, scale multiply, clamp and counter
// read, then write-back; the response is registered at write-back. A new
// request is taken only once the last has left write-back, set by the single
// shared port pair of the counter memory and the one-request-at-a-time sequencer.
// The response register lets the next request start while a response waits;
// if it is still stalled at write-back, the sequencer holds there.
// After reset a clearing pass zeroes the 3072 counters, one per cycle, so
// req_stall stays high until the pass has ended; csr_ writes are taken
// at any time but must only be made while the block is idle.
// The csr_ port writes half_range, bin_scale and bins_in_use by index.
module clamped_velocity_histogram (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic signed [31:0] req_sample,
   input  logic [1:0]  req_atom_type,
   input  logic [1:0]  req_axis,
   input  logic [7:0]  req_bin_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_count,
   output logic [7:0]  rsp_bin_used,
   output logic        rsp_saturated,
   output logic        rsp_clamped,
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_wdata
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_LOOK  = 5'b01000,
      ST_WB    = 5'b10000
   } state_type;

   localparam int CW  = cvh_pkg::COUNT_WIDTH;
   localparam int BW  = cvh_pkg::BIN_W;
   localparam int AW  = cvh_pkg::ADDR_W;

   state_type state_ff, state_in;

   logic [30:0] half_range_ff, half_range_in;
   logic [30:0] bin_scale_ff, bin_scale_in;
   logic [8:0]  bins_in_use_ff, bins_in_use_in;

   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // captured request
   cvh_pkg::op_type op_ff;
   logic [1:0]      type_ff;
   logic [1:0]      axis_ff;
   logic [7:0]      bin_index_ff;

   // lookup results held for write-back
   logic [AW-1:0] addr_ff;
   logic [BW-1:0] bin_ff;
   logic          clamped_ff;
   logic          hit_ff;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_count_ff;
   logic [7:0]    rsp_bin_ff;
   logic          rsp_sat_ff;
   logic          rsp_clamped_ff;

   cvh_pkg::calc_ctl_type calc_ctl;
   cvh_pkg::loc_type      loc;

   logic                req_accept;
   logic                wb_go;
   logic                row_ok;
   logic                idx_ok;
   logic [BW+7:0]       idx_wide;
   logic [BW-1:0]       look_bin;
   logic                look_hit;
   logic [31:0]         addr_full;
   logic [AW-1:0]       look_addr;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [CW-1:0]       ram_wdata;
   logic [CW-1:0]       ram_rdata;

   logic [CW-1:0]       new_count;
   logic [CW+31:0]      count_wide;
   logic [BW+7:0]       bin_wide;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Configuration registers
   always_comb begin
      half_range_in  = half_range_ff;
      bin_scale_in   = bin_scale_ff;
      bins_in_use_in = bins_in_use_ff;
      if (csr_we) begin
         unique case (cvh_pkg::csr_index_type'(csr_index))
            cvh_pkg::CSR_HALF_RANGE:  half_range_in  = csr_wdata;
            cvh_pkg::CSR_BIN_SCALE:   bin_scale_in   = csr_wdata;
            cvh_pkg::CSR_BINS_IN_USE: bins_in_use_in = csr_wdata[8:0];
            cvh_pkg::CSR_NONE:        ;
         endcase
      end
   end

   // Bin locator
   assign calc_ctl.load_sum  = req_accept;
   assign calc_ctl.load_prod = (state_ff == ST_MUL);

   cvh_bin_calc u_bin_calc (
      .clock       (clock),
      .ctl         (calc_ctl),
      .sample      (req_sample),
      .half_range  (half_range_ff),
      .bin_scale   (bin_scale_ff),
      .bins_in_use (bins_in_use_ff),
      .loc         (loc)
   );

   // Row and bin selection for the lookup
   assign row_ok   = (32'(type_ff) < 32'(cvh_pkg::MAX_TYPES)) &&
                     (32'(axis_ff) < 32'(cvh_pkg::AXES));
   assign idx_ok   = 32'(bin_index_ff) < 32'(cvh_pkg::BINS);
   assign idx_wide = {{BW{1'b0}}, bin_index_ff};

   always_comb begin
      unique case (op_ff)
         cvh_pkg::OP_ACCUMULATE: begin
            look_bin = loc.bin;
            look_hit = row_ok;
         end
         cvh_pkg::OP_READ, cvh_pkg::OP_CLEAR: begin
            look_bin = idx_wide[BW-1:0];
            look_hit = row_ok && idx_ok;
         end
         cvh_pkg::OP_UNUSED: begin
            look_bin = '0;
            look_hit = 1'b0;
         end
      endcase
   end

   assign addr_full = (32'(type_ff) * 32'(cvh_pkg::AXES) + 32'(axis_ff)) *
                      32'(cvh_pkg::BINS) + 32'(look_bin);
   assign look_addr = addr_full[AW-1:0];

   // Write-back proceeds once the response register is free
   assign wb_go = (state_ff == ST_WB) && (!rsp_valid_ff || !rsp_stall);

   // Modified counter
   always_comb begin
      unique case (op_ff)
         cvh_pkg::OP_ACCUMULATE:
            new_count = (ram_rdata == cvh_pkg::COUNT_MAX) ? ram_rdata : ram_rdata + CW'(1);
         cvh_pkg::OP_CLEAR:
            new_count = '0;
         cvh_pkg::OP_READ, cvh_pkg::OP_UNUSED:
            new_count = ram_rdata;
      endcase
   end

   assign count_wide = {32'd0, new_count};
   assign bin_wide   = {8'd0, bin_ff};

   // Counter memory ports: clearing pass or write-back
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = new_count;
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = '0;
      end else if (wb_go && hit_ff &&
                   (op_ff == cvh_pkg::OP_ACCUMULATE || op_ff == cvh_pkg::OP_CLEAR)) begin
         ram_we = 1'b1;
      end
   end

   cvh_count_ram u_count_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (look_addr),
      .rd_data (ram_rdata)
   );

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(cvh_pkg::DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_LOOK;
         ST_LOOK: state_in = ST_WB;
         ST_WB: begin
            if (wb_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Response valid: set at write-back, dropped when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (wb_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         half_range_ff  <= cvh_pkg::HALF_RANGE_RESET;
         bin_scale_ff   <= cvh_pkg::BIN_SCALE_RESET;
         bins_in_use_ff <= cvh_pkg::BINS_IN_USE_RESET;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         rsp_valid_ff   <= rsp_valid_in;
         half_range_ff  <= half_range_in;
         bin_scale_ff   <= bin_scale_in;
         bins_in_use_ff <= bins_in_use_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff        <= cvh_pkg::op_type'(req_operation);
         type_ff      <= req_atom_type;
         axis_ff      <= req_axis;
         bin_index_ff <= req_bin_index;
      end
      if (state_ff == ST_LOOK) begin
         addr_ff    <= look_addr;
         bin_ff     <= look_bin;
         clamped_ff <= loc.clamped && (op_ff == cvh_pkg::OP_ACCUMULATE) && row_ok;
         hit_ff     <= look_hit;
      end
      if (wb_go) begin
         rsp_bin_ff     <= bin_wide[7:0];
         rsp_clamped_ff <= clamped_ff;
         if (hit_ff) begin
            rsp_count_ff <= count_wide[31:0];
            rsp_sat_ff   <= (new_count == cvh_pkg::COUNT_MAX);
         end else begin
            rsp_count_ff <= '0;
            rsp_sat_ff   <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_bin_used  = rsp_bin_ff;
   assign rsp_saturated = rsp_sat_ff;
   assign rsp_clamped   = rsp_clamped_ff;

   // Counter writes outside the clearing pass happen only at write-back
   a_write_in_wb: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != ST_CLEAR) |-> (state_ff == ST_WB && hit_ff))
      else $error("counter written outside write-back");

   // A stalled, undelivered response holds the sequencer at write-back
   a_wb_interlock: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WB && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_WB))
      else $error("write-back left while response register busy");

   // No response appears while the clearing pass runs
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rsp_valid_ff && req_stall))
      else $error("activity during clearing pass");

   // An accepted request steps through lookup to write-back
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> ##1 (state_ff == ST_LOOK) ##1 (state_ff == ST_WB))
      else $error("sequencer skipped a step");

endmodule

### rtl/cvh_bin_calc.sv
// Bin locator: offset sum, fixed-point scale multiply and clamp.
module cvh_bin_calc (
   input  logic                 clock,
   input  cvh_pkg::calc_ctl_type ctl,
   input  logic signed [31:0]   sample,
   input  logic [30:0]          half_range,
   input  logic [30:0]          bin_scale,
   input  logic [8:0]           bins_in_use,
   output cvh_pkg::loc_type     loc
);

   logic signed [32:0]        sum_ff;
   logic signed [32:0]        sum_in;
   logic [62:0]               prod_ff;
   logic [62:0]               prod_in;
   logic                      below_ff;
   logic [30:0]               idx;
   logic [cvh_pkg::BIN_W-1:0] top;

   // Offset into the non-negative range, exact in 33 bits
   assign sum_in = 33'(sample) + $signed({2'b00, half_range});

   // Q16.16 times Q16.16 gives Q32.32; the integer part is the bin
   assign prod_in = 63'(sum_ff[31:0]) * 63'(bin_scale);

   always_ff @(posedge clock) begin
      if (ctl.load_sum) begin
         sum_ff <= sum_in;
      end
      if (ctl.load_prod) begin
         prod_ff  <= prod_in;
         below_ff <= sum_ff[32];
      end
   end

   assign idx = prod_ff[62:32];

   // Highest usable bin: zero acts as one, oversize acts as the full row
   always_comb begin
      priority if (bins_in_use == 9'd0) begin
         top = '0;
      end else if (32'(bins_in_use) > 32'(cvh_pkg::BINS)) begin
         top = cvh_pkg::BIN_W'(cvh_pkg::BINS - 1);
      end else begin
         top = cvh_pkg::BIN_W'(bins_in_use - 9'd1);
      end
   end

   // Clamp below and above the range
   always_comb begin
      priority if (below_ff) begin
         loc.bin     = '0;
         loc.clamped = 1'b1;
      end else if (idx > 31'(top)) begin
         loc.bin     = top;
         loc.clamped = 1'b1;
      end else begin
         loc.bin     = idx[cvh_pkg::BIN_W-1:0];
         loc.clamped = 1'b0;
      end
   end

endmodule

### rtl/cvh_count_ram.sv
// Counter store: one write port, one read port with registered data.
module cvh_count_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [cvh_pkg::ADDR_W-1:0]    wr_addr,
   input  logic [cvh_pkg::COUNT_WIDTH-1:0] wr_data,
   input  logic [cvh_pkg::ADDR_W-1:0]    rd_addr,
   output logic [cvh_pkg::COUNT_WIDTH-1:0] rd_data
);

   logic [cvh_pkg::COUNT_WIDTH-1:0] ram [cvh_pkg::DEPTH];
   logic [cvh_pkg::COUNT_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram[wr_addr] <= wr_data;
      end
      rd_data_ff <= ram[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/cvh_response_checker.sv
// Response checker for the clamped velocity histogram: watches requests, predicts, compares.
module cvh_response_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_sample,
   input  logic [1:0]         req_atom_type,
   input  logic [1:0]         req_axis,
   input  logic [7:0]         req_bin_index,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [31:0]        rsp_count,
   input  logic [7:0]         rsp_bin_used,
   input  logic               rsp_saturated,
   input  logic               rsp_clamped,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_wdata,
   output int                 mismatches,
   output int                 awaited,
   output int                 responses_seen
);

   typedef struct packed {
      logic [31:0] count;
      logic [7:0]  bin_used;
      logic        saturated;
      logic        clamped;
   } bin_response_type;

   // Shadow of the counter memory and of the registers
   logic [cvh_pkg::COUNT_WIDTH-1:0] counter_image [cvh_pkg::DEPTH];
   logic [30:0]            half_range_q;
   logic [30:0]            bin_scale_q;
   logic [8:0]             bins_in_use_q;

   bin_response_type awaited_responses [$];
   int               mismatch_total = 0;
   int               seen_total = 0;

   // 0 behaves as 1, anything past the row length as the full row
   function automatic logic [8:0] usable_bins(input logic [8:0] n);
      if (n == 9'd0) return 9'd1;
      if (n > 9'(cvh_pkg::BINS)) return 9'(cvh_pkg::BINS);
      return n;
   endfunction

   // Offset, scale and floor, then clamp into the bins in use
   task automatic locate_bin(input logic [31:0] velocity, output logic [7:0] bin,
                             output logic clamped);
      logic signed [33:0] offset_sum;
      logic [63:0]        product;
      logic [31:0]        floor_idx;
      logic [8:0]         top;
      top        = usable_bins(bins_in_use_q) - 9'd1;
      offset_sum = $signed({{2{velocity[31]}}, velocity}) + $signed({3'b000, half_range_q});
      if (offset_sum[33]) begin
         bin     = 8'd0;
         clamped = 1'b1;
      end else begin
         product   = {32'd0, offset_sum[31:0]} * {33'd0, bin_scale_q};
         floor_idx = product[63:32];
         if (floor_idx > {23'd0, top}) begin
            bin     = top[7:0];
            clamped = 1'b1;
         end else begin
            bin     = floor_idx[7:0];
            clamped = 1'b0;
         end
      end
   endtask

   // Applies one request to the shadow memory and forms its response
   task automatic predict_histogram_op(input cvh_pkg::op_type op,
                                       input logic [31:0] velocity,
                                       input logic [1:0] atom, input logic [1:0] axis,
                                       input logic [7:0] bidx,
                                       output bin_response_type r);
      logic        row_ok;
      int unsigned row_base;
      int unsigned slot;
      logic [7:0]  bin;
      logic        clamped;
      r        = '0;
      row_ok   = (atom < cvh_pkg::MAX_TYPES) && (axis < cvh_pkg::AXES);
      row_base = (int'(atom) * cvh_pkg::AXES + int'(axis)) * cvh_pkg::BINS;
      case (op)
         cvh_pkg::OP_ACCUMULATE: begin
            locate_bin(velocity, bin, clamped);
            r.bin_used = bin;
            if (row_ok) begin
               slot = row_base + bin;
               if (counter_image[slot] != cvh_pkg::COUNT_MAX) counter_image[slot] += 1'b1;
               r.count     = counter_image[slot];
               r.saturated = (counter_image[slot] == cvh_pkg::COUNT_MAX);
               r.clamped   = clamped;
            end
         end
         cvh_pkg::OP_READ, cvh_pkg::OP_CLEAR: begin
            r.bin_used = bidx;
            if (row_ok && bidx < cvh_pkg::BINS) begin
               slot = row_base + bidx;
               if (op == cvh_pkg::OP_CLEAR) counter_image[slot] = '0;
               r.count     = counter_image[slot];
               r.saturated = (counter_image[slot] == cvh_pkg::COUNT_MAX);
            end
         end
         default: r = '0;
      endcase
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         mismatch_total++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      bin_response_type want;
      if (reset) begin
         foreach (counter_image[i]) counter_image[i] = '0;
         half_range_q  = cvh_pkg::HALF_RANGE_RESET;
         bin_scale_q   = cvh_pkg::BIN_SCALE_RESET;
         bins_in_use_q = cvh_pkg::BINS_IN_USE_RESET;
         awaited_responses.delete();
      end else begin
         // response side first: it always belongs to an older request
         if (rsp_valid && !rsp_stall) begin
            seen_total++;
            if (awaited_responses.size() == 0) begin
               mismatch_total++;
               $display("%0t: response with none awaited, expected none, actual count %0h bin %0h",
                        $time, rsp_count, rsp_bin_used);
            end else begin
               want = awaited_responses.pop_front();
               check_field("count", want.count, rsp_count);
               check_field("bin_used", 32'(want.bin_used), 32'(rsp_bin_used));
               check_field("saturated", 32'(want.saturated), 32'(rsp_saturated));
               check_field("clamped", 32'(want.clamped), 32'(rsp_clamped));
            end
         end
         // register writes
         if (csr_we) begin
            case (cvh_pkg::csr_index_type'(csr_index))
               cvh_pkg::CSR_HALF_RANGE:  half_range_q  = csr_wdata;
               cvh_pkg::CSR_BIN_SCALE:   bin_scale_q   = csr_wdata;
               cvh_pkg::CSR_BINS_IN_USE: bins_in_use_q = csr_wdata[8:0];
               default: ;
            endcase
         end
         // accepted request
         if (req_valid && !req_stall) begin
            predict_histogram_op(cvh_pkg::op_type'(req_operation), req_sample,
                                 req_atom_type, req_axis, req_bin_index, want);
            awaited_responses.push_back(want);
         end
      end
      mismatches     <= mismatch_total;
      awaited        <= awaited_responses.size();
      responses_seen <= seen_total;
   end

endmodule

### tb/clamped_velocity_histogram_tb.sv
// Testbench top for the clamped velocity histogram: stimulus, register settings and verdict.
module clamped_velocity_histogram_tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 200;
   localparam int PHASES       = 8;

   typedef struct {
      cvh_pkg::op_type op;
      logic [31:0]     velocity;
      logic [1:0]      atom;
      logic [1:0]      axis;
      logic [7:0]      bidx;
   } hist_req_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_operation;
   logic signed [31:0] req_sample;
   logic [1:0]         req_atom_type;
   logic [1:0]         req_axis;
   logic [7:0]         req_bin_index;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [31:0]        rsp_count;
   logic [7:0]         rsp_bin_used;
   logic               rsp_saturated;
   logic               rsp_clamped;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [30:0]        csr_wdata;

   int mismatches;
   int awaited;
   int responses_seen;

   int          send_idle_pct;
   int          recv_idle_pct;
   int          requests_sent;
   int          settings_used;
   int          cycle_count;
   longint      cur_half_range;
   logic [8:0]  cur_bins;

   clamped_velocity_histogram dut (.*);

   cvh_response_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop if the block hangs
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // Receiver back-pressure
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic hist_req_type make_req(input cvh_pkg::op_type op,
                                             input logic [31:0] velocity,
                                             input logic [1:0] atom, input logic [1:0] axis,
                                             input logic [7:0] bidx);
      hist_req_type r;
      r.op       = op;
      r.velocity = velocity;
      r.atom     = atom;
      r.axis     = axis;
      r.bidx     = bidx;
      return r;
   endfunction

   // Q16.16 scale for nb bins over twice hr, kept inside the register range
   function automatic logic [30:0] fit_scale(input longint nb, input longint hr);
      longint v;
      v = (nb << 31) / hr;
      if (v < 1) v = 1;
      if (v > 64'h7fffffff) v = 64'h7fffffff;
      return v[30:0];
   endfunction

   // Mostly near the range, with its edges and the odd raw 32-bit value
   function automatic logic [31:0] pick_velocity();
      longint span;
      longint v;
      int     pick;
      pick = $urandom_range(9);
      span = cur_half_range + cur_half_range / 4 + 1;
      if (pick == 0) return $urandom;
      if (pick == 1) begin
         case ($urandom_range(5))
            0: v = -cur_half_range - 1;
            1: v = -cur_half_range;
            2: v = cur_half_range - 1;
            3: v = cur_half_range;
            4: v = -64'sd2147483648;
            default: v = 64'sd2147483647;
         endcase
      end else begin
         v = longint'({$urandom, $urandom} % (2 * span + 1)) - span;
      end
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      return v[31:0];
   endfunction

   function automatic hist_req_type random_req();
      hist_req_type r;
      int           k;
      int           live_bins;
      live_bins = (cur_bins == 0) ? 1 :
                  (cur_bins > cvh_pkg::BINS) ? cvh_pkg::BINS : int'(cur_bins);
      k = $urandom_range(99);
      r.op       = (k < 55) ? cvh_pkg::OP_ACCUMULATE : (k < 75) ? cvh_pkg::OP_READ :
                   (k < 93) ? cvh_pkg::OP_CLEAR : cvh_pkg::OP_UNUSED;
      r.velocity = pick_velocity();
      r.atom     = 2'($urandom_range(3));
      r.axis     = ($urandom_range(99) < 6) ? 2'd3 : 2'($urandom_range(2));
      r.bidx     = ($urandom_range(99) < 70) ? 8'($urandom_range(live_bins - 1))
                                             : 8'($urandom_range(255));
      return r;
   endfunction

   // Presents one request and holds it until taken
   task automatic issue_request(input hist_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_operation <= r.op;
      req_sample    <= r.velocity;
      req_atom_type <= r.atom;
      req_axis      <= r.axis;
      req_bin_index <= r.bidx;
      do @(posedge clock); while (req_stall !== 1'b0);
      requests_sent++;
   endtask

   // Drop valid and let every awaited response drain
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input cvh_pkg::csr_index_type idx, input logic [30:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic program_histogram(input logic [30:0] hr, input logic [30:0] scale,
                                    input logic [8:0] nb);
      write_reg(cvh_pkg::CSR_HALF_RANGE, hr);
      write_reg(cvh_pkg::CSR_BIN_SCALE, scale);
      write_reg(cvh_pkg::CSR_BINS_IN_USE, {22'd0, nb});
      cur_half_range = longint'(hr);
      cur_bins       = nb;
      settings_used++;
   endtask

   initial begin
      hist_req_type directed [$];
      logic [30:0]  hr;
      logic [30:0]  scale;
      logic [8:0]   nb;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = cvh_pkg::OP_ACCUMULATE;
      req_sample    = '0;
      req_atom_type = '0;
      req_axis      = '0;
      req_bin_index = '0;
      csr_we        = 1'b0;
      csr_index     = cvh_pkg::CSR_HALF_RANGE;
      csr_wdata     = '0;
      send_idle_pct = 25;
      recv_idle_pct = 60;
      requests_sent = 0;
      settings_used = 1;
      cur_half_range = longint'(cvh_pkg::HALF_RANGE_RESET);
      cur_bins       = cvh_pkg::BINS_IN_USE_RESET;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at reset settings: one unit each side, 512 raw per bin
      directed.push_back(make_req(cvh_pkg::OP_ACCUMULATE, 32'd0, 2'd0, 2'd0, 8'd0));
      directed.push_back(make_req(cvh_pkg::OP_ACCUMULATE, 32'd0, 2'd0, 2'd0, 8'd0));
      directed.push_back(make_req(cvh_pkg::OP_ACCUMULATE, -32'sd65536, 2'd0, 2'd0, 8'd0));
      // below the range
      directed.push_back(make_req(cvh_pkg::OP_ACCUMULATE, -32'sd65537, 2'd0, 2'd0, 8'd0));
      directed.push_back(make_req(cvh_pkg::OP_ACCUMULATE, 32'h8000_0000, 2'd3, 2'd2, 8'hff));
      // above the range, and the fractional edge just under it
      directed.push_back(make_req(cvh_pkg::OP_ACCUMULATE, 32'h7fff_ffff, 2'd3, 2'd2, 8'd0));
      directed.push_back(make_req(cvh_pkg::OP_ACCUMULATE, 32'd65535, 2'd1, 2'd0, 8'd0));
      directed.push_back(make_req(cvh_pkg::OP_ACCUMULATE, 32'd65536, 2'd1, 2'd0, 8'd0));
      // axis 3 is not a row
      directed.push_back(make_req(cvh_pkg::OP_ACCUMULATE, 32'd1000, 2'd2, 2'd3, 8'd0));
      directed.push_back(make_req(cvh_pkg::OP_READ, 32'd0, 2'd0, 2'd0, 8'd128));
      directed.push_back(make_req(cvh_pkg::OP_READ, 32'd0, 2'd0, 2'd0, 8'd0));
      directed.push_back(make_req(cvh_pkg::OP_CLEAR, 32'hffff_ffff, 2'd0, 2'd0, 8'd128));
      directed.push_back(make_req(cvh_pkg::OP_READ, 32'd0, 2'd0, 2'd0, 8'd128));
      directed.push_back(make_req(cvh_pkg::OP_READ, 32'd0, 2'd3, 2'd2, 8'd255));
      directed.push_back(make_req(cvh_pkg::OP_CLEAR, 32'd0, 2'd1, 2'd3, 8'd255));
      directed.push_back(make_req(cvh_pkg::OP_READ, 32'd0, 2'd3, 2'd3, 8'd7));
      directed.push_back(make_req(cvh_pkg::OP_UNUSED, 32'hdead_beef, 2'd3, 2'd3, 8'hff));
      directed.push_back(make_req(cvh_pkg::OP_READ, 32'd0, 2'd3, 2'd2, 8'd0));
      directed.push_back(make_req(cvh_pkg::OP_ACCUMULATE, 32'h5555_aaaa, 2'd1, 2'd1, 8'h55));
      directed.push_back(make_req(cvh_pkg::OP_ACCUMULATE, 32'haaaa_5555, 2'd2, 2'd0, 8'haa));
      directed.push_back(make_req(cvh_pkg::OP_READ, 32'd0, 2'd0, 2'd1, 8'd255));
      foreach (directed[i]) issue_request(directed[i]);

      // Random phases, each under its own register setting
      for (int phase = 1; phase <= PHASES; phase++) begin
         wait_idle();
         if (phase == 3) begin
            send_idle_pct = 60;
            recv_idle_pct = 25;
         end
         if (phase == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            1: begin
               hr = 31'd262144; nb = 9'd8; scale = 31'd65536;
            end
            2: begin
               hr = 31'h7fff_ffff; nb = 9'd256; scale = fit_scale(256, hr);
            end
            3: begin
               // narrowest range, two bins, steepest scale
               hr = 31'd1; nb = 9'd2; scale = 31'h7fff_ffff;
            end
            4: begin
               hr = 31'($urandom_range(1 << 10, 1 << 28));
               nb = 9'($urandom_range(2, 256));
               scale = fit_scale(nb, hr);
            end
            5: begin
               // no bins in use and a zero scale
               hr = 31'($urandom_range(1, 32'h7fff_ffff)); nb = 9'd0; scale = 31'd0;
            end
            6: begin
               // bins in use past the row; scale a bit steep so the top clamps
               hr = 31'd524288; nb = 9'd511;
               scale = fit_scale(256, hr) + 31'd65536;
            end
            7: begin
               hr = 31'($urandom_range(1, 32'h7fff_ffff));
               nb = 9'($urandom_range(2, 256));
               scale = fit_scale(nb, hr);
            end
            default: begin
               hr = 31'd1048576; nb = 9'd1; scale = 31'($urandom);
            end
         endcase
         program_histogram(hr, scale, nb);
         repeat (PHASE_ITEMS) issue_request(random_req());
      end
      wait_idle();

      $display("Run: %0d requests sent, %0d responses checked, %0d register settings",
               requests_sent, responses_seen, settings_used);
      $display("Ops: accumulate, read, clear, unused; clamps both ends, bad axis, odd bin counts");
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
